/* design/s5ch_pkg.sv */
// ----------------------------------------------------------------------------
// s5ch_pkg
// Shared types and constants for the SOCKS5 client handshake core.
// ----------------------------------------------------------------------------
`default_nettype none

package s5ch_pkg;

  // item kinds
  localparam logic [1:0] FN_NET_BYTE  = 2'd0;
  localparam logic [1:0] FN_APP_BYTE  = 2'd1;
  localparam logic [1:0] FN_NET_CLOSE = 2'd2;
  localparam logic [1:0] FN_APP_CLOSE = 2'd3;

  // handshake phases
  localparam logic [2:0] PH_METHOD = 3'd0;
  localparam logic [2:0] PH_AUTH   = 3'd1;
  localparam logic [2:0] PH_REPLY  = 3'd2;
  localparam logic [2:0] PH_EST    = 3'd3;
  localparam logic [2:0] PH_FATAL  = 3'd4;

  // send requests
  localparam logic [1:0] SEND_NONE    = 2'd0;
  localparam logic [1:0] SEND_CREDS   = 2'd1;
  localparam logic [1:0] SEND_CONNECT = 2'd2;

  // fault causes
  localparam logic [3:0] FLT_NONE          = 4'd0;
  localparam logic [3:0] FLT_METH_VER      = 4'd1;
  localparam logic [3:0] FLT_NO_METHOD     = 4'd2;
  localparam logic [3:0] FLT_METH_UNOFFER  = 4'd3;
  localparam logic [3:0] FLT_NO_CREDS      = 4'd4;
  localparam logic [3:0] FLT_AUTH_VER      = 4'd5;
  localparam logic [3:0] FLT_AUTH_REJECT   = 4'd6;
  localparam logic [3:0] FLT_REPLY_VER     = 4'd7;
  localparam logic [3:0] FLT_ADDR_TYPE     = 4'd8;
  localparam logic [3:0] FLT_REFUSED       = 4'd9;
  localparam logic [3:0] FLT_NET_CLOSED    = 4'd10;
  localparam logic [3:0] FLT_SIDE_CLOSED   = 4'd11;

  // protocol bytes
  localparam logic [7:0] SOCKS_VER      = 8'h05;
  localparam logic [7:0] AUTH_VER       = 8'h01;
  localparam logic [7:0] METH_NONE      = 8'h00;
  localparam logic [7:0] METH_USERPASS  = 8'h02;
  localparam logic [7:0] METH_REJECT    = 8'hff;
  localparam logic [7:0] ATYP_IPV4      = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
  localparam logic [7:0] ATYP_IPV6      = 8'h04;

  // reply lengths: header (3) plus address type, address and port
  localparam logic [8:0] REPLY_LEN_IPV4 = 9'd3 + 9'd1 + 9'd4 + 9'd2;
  localparam logic [8:0] REPLY_LEN_IPV6 = 9'd3 + 9'd1 + 9'd16 + 9'd2;
  localparam logic [8:0] REPLY_LEN_DOM  = 9'd3 + 9'd1 + 9'd1 + 9'd2;

  // configuration port
  localparam int          CFG_AW     = 3;
  localparam logic        REG_CREDS  = 1'b0;

  typedef struct packed {
    logic       accepted;
    logic       to_net_valid;
    logic [7:0] to_net_byte;
    logic       to_app_valid;
    logic [7:0] to_app_byte;
    logic [1:0] send_message;
    logic [2:0] phase_now;
    logic [3:0] fault_code;
    logic [7:0] server_reply;
  } res_t;

endpackage

`default_nettype wire

/* design/s5ch_if.sv */
// ----------------------------------------------------------------------------
// s5ch_if
// Valid/ready channels for items in and results out of the handshake core.
// ----------------------------------------------------------------------------
`default_nettype none

interface s5ch_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface s5ch_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic       to_net_valid;
  logic [7:0] to_net_byte;
  logic       to_app_valid;
  logic [7:0] to_app_byte;
  logic [1:0] send_message;
  logic [2:0] phase_now;
  logic [3:0] fault_code;
  logic [7:0] server_reply;

  modport source (output valid, output accepted, output to_net_valid, output to_net_byte,
                  output to_app_valid, output to_app_byte, output send_message,
                  output phase_now, output fault_code, output server_reply,
                  input ready);
  modport sink   (input valid, input accepted, input to_net_valid, input to_net_byte,
                  input to_app_valid, input to_app_byte, input send_message,
                  input phase_now, input fault_code, input server_reply,
                  output ready);
endinterface

`default_nettype wire

/* design/socks5_client_handshake_core.sv */
// ----------------------------------------------------------------------------
// socks5_client_handshake_core
// Client-side SOCKS5 handshake tracker with byte pass-through once established.
// ----------------------------------------------------------------------------
// Results land in the output register, or in the skid stage while it stalls.
// Throughput: one transaction per cycle while the skid stage is empty; the
//   phase/position update is a single compare-and-add feeding state and result.
// A skid stage behind the output register keeps input ready for one extra
//   transaction while a result is stalled.
// Reset (rst_n, synchronous): method phase, all counters and flags cleared.
`default_nettype none

module socks5_client_handshake_core (
  input  wire                          clk,
  input  wire                          rst_n,
  s5ch_in_if.sink                      in_ch,
  s5ch_out_if.source                   out_ch,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [s5ch_pkg::CFG_AW-1:0]   paddr,
  input  wire [31:0]                   pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import s5ch_pkg::*;

  // configuration
  logic cred_r;

  // handshake state
  logic [2:0] phase_r,  phase_nxt;
  logic [8:0] pos_r,    pos_nxt;
  logic       fbg_r,    fbg_nxt;
  logic [7:0] rcode_r,  rcode_nxt;
  logic [8:0] rlen_r,   rlen_nxt;
  logic [3:0] hfault_r, hfault_nxt;
  logic       appcl_r,  appcl_nxt;
  logic       netcl_r,  netcl_nxt;

  // output register and skid stage
  res_t out_r, skid_r, res;
  logic out_vld_r, skid_vld_r;

  logic in_fire;
  logic out_take;

  // ---------------------------------------------------------------------------
  // APB register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CREDS)) begin
      cred_r <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CREDS) begin
      prdata = {31'd0, cred_r};
    end
  end

  // ---------------------------------------------------------------------------
  // next state and result
  always_comb begin
    logic [7:0] b;
    logic [8:0] rlen_v;
    logic [8:0] pos_inc;
    logic       fatal;
    logic [3:0] fcode;
    logic [7:0] want;

    b        = in_ch.data_byte;
    rlen_v   = rlen_r;
    pos_inc  = pos_r + 9'd1;
    fatal    = 1'b0;
    fcode    = FLT_NONE;
    want     = (phase_r == PH_METHOD) ? SOCKS_VER : AUTH_VER;

    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    fbg_nxt    = fbg_r;
    rcode_nxt  = rcode_r;
    rlen_nxt   = rlen_r;
    hfault_nxt = hfault_r;
    appcl_nxt  = appcl_r;
    netcl_nxt  = netcl_r;

    res = '0;

    case (in_ch.func)
      FN_NET_BYTE: begin
        if (phase_r == PH_FATAL) begin
          res.accepted = 1'b0;
        end else if (netcl_r) begin
          res.fault_code = FLT_SIDE_CLOSED;
        end else begin
          res.accepted = 1'b1;
          if (phase_r == PH_EST) begin
            res.to_app_valid = 1'b1;
            res.to_app_byte  = b;
          end else if (phase_r inside {PH_METHOD, PH_AUTH}) begin
            if (pos_r == 9'd0) begin
              fbg_nxt = (b == want);
              pos_nxt = 9'd1;
            end else begin
              pos_nxt = 9'd0;
              if (phase_r == PH_METHOD) begin
                if (!fbg_r) begin
                  fatal = 1'b1; fcode = FLT_METH_VER;
                end else if (b == METH_NONE) begin
                  phase_nxt = PH_REPLY;
                  rlen_nxt  = 9'd0;
                  res.send_message = SEND_CONNECT;
                end else if (b == METH_USERPASS) begin
                  if (!cred_r) begin
                    fatal = 1'b1; fcode = FLT_NO_CREDS;
                  end else begin
                    phase_nxt = PH_AUTH;
                    res.send_message = SEND_CREDS;
                  end
                end else begin
                  fatal = 1'b1;
                  fcode = (b == METH_REJECT) ? FLT_NO_METHOD : FLT_METH_UNOFFER;
                end
              end else begin
                if (!fbg_r) begin
                  fatal = 1'b1; fcode = FLT_AUTH_VER;
                end else if (b != 8'd0) begin
                  fatal = 1'b1; fcode = FLT_AUTH_REJECT;
                end else begin
                  phase_nxt = PH_REPLY;
                  rlen_nxt  = 9'd0;
                  res.send_message = SEND_CONNECT;
                end
              end
            end
          end else if (phase_r == PH_REPLY) begin
            if (pos_r == 9'd0) begin
              fbg_nxt = (b == SOCKS_VER);
              rlen_v  = 9'd0;
            end else if (pos_r == 9'd1) begin
              rcode_nxt = b;
            end else if (pos_r == 9'd3) begin
              if (!fbg_r) begin
                fatal = 1'b1; fcode = FLT_REPLY_VER;
              end else if (b == ATYP_IPV4) begin
                rlen_v = REPLY_LEN_IPV4;
              end else if (b == ATYP_IPV6) begin
                rlen_v = REPLY_LEN_IPV6;
              end else if (b == ATYP_DOMAIN) begin
                rlen_v = 9'd0;
              end else begin
                fatal = 1'b1; fcode = FLT_ADDR_TYPE;
              end
            end else if (pos_r == 9'd4 && rlen_v == 9'd0) begin
              // domain name: its length byte sets the total
              rlen_v = REPLY_LEN_DOM + {1'b0, b};
            end
            rlen_nxt = rlen_v;
            if (!fatal) begin
              if (rlen_v != 9'd0 && pos_inc >= rlen_v) begin
                pos_nxt  = 9'd0;
                rlen_nxt = 9'd0;
                if (rcode_r != 8'd0) begin
                  fatal = 1'b1; fcode = FLT_REFUSED;
                end else begin
                  phase_nxt = PH_EST;
                end
              end else begin
                pos_nxt = pos_inc;
              end
            end
          end
        end
      end
      FN_APP_BYTE: begin
        if (phase_r == PH_FATAL) begin
          res.accepted = 1'b0;
        end else if (appcl_r) begin
          res.fault_code = FLT_SIDE_CLOSED;
        end else if (phase_r == PH_EST) begin
          res.accepted     = 1'b1;
          res.to_net_valid = 1'b1;
          res.to_net_byte  = b;
        end
      end
      FN_NET_CLOSE: begin
        res.accepted = 1'b1;
        netcl_nxt    = 1'b1;
        if (phase_r != PH_EST && phase_r != PH_FATAL) begin
          fatal = 1'b1; fcode = FLT_NET_CLOSED;
        end
      end
      default: begin
        res.accepted = 1'b1;
        appcl_nxt    = 1'b1;
      end
    endcase

    if (fatal) begin
      phase_nxt  = PH_FATAL;
      hfault_nxt = fcode;
      pos_nxt    = 9'd0;
    end

    if (phase_nxt == PH_FATAL) begin
      res.fault_code = hfault_nxt;
    end
    res.phase_now = phase_nxt;
    if (phase_nxt == PH_FATAL && hfault_nxt == FLT_REFUSED) begin
      res.server_reply = rcode_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // handshake
  assign in_ch.ready = !skid_vld_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_take    = !out_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_METHOD;
      pos_r    <= '0;
      fbg_r    <= 1'b0;
      rcode_r  <= '0;
      rlen_r   <= '0;
      hfault_r <= FLT_NONE;
      appcl_r  <= 1'b0;
      netcl_r  <= 1'b0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      fbg_r    <= fbg_nxt;
      rcode_r  <= rcode_nxt;
      rlen_r   <= rlen_nxt;
      hfault_r <= hfault_nxt;
      appcl_r  <= appcl_nxt;
      netcl_r  <= netcl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_take) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r  <= in_fire;
      end
    end else if (in_fire) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_r <= skid_vld_r ? skid_r : res;
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.accepted     = out_r.accepted;
  assign out_ch.to_net_valid = out_r.to_net_valid;
  assign out_ch.to_net_byte  = out_r.to_net_byte;
  assign out_ch.to_app_valid = out_r.to_app_valid;
  assign out_ch.to_app_byte  = out_r.to_app_byte;
  assign out_ch.send_message = out_r.send_message;
  assign out_ch.phase_now    = out_r.phase_now;
  assign out_ch.fault_code   = out_r.fault_code;
  assign out_ch.server_reply = out_r.server_reply;

  // ---------------------------------------------------------------------------
  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid stage holds a result while the output register is empty");

  a_fatal_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FATAL |=> phase_r == PH_FATAL)
    else $error("left the fatal phase");

  a_fault_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FATAL) == (hfault_r != FLT_NONE))
    else $error("held fault out of step with the fatal phase");

  a_reply_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_REPLY |-> pos_r < (REPLY_LEN_DOM + 9'd255))
    else $error("reply byte position past the longest reply");

endmodule

`default_nettype wire

/* bench/s5ch_result_checker.sv */
// ----------------------------------------------------------------------------
// s5ch_result_checker
// Watches the item and result channels of the SOCKS5 handshake core, tracks
// the client side of the exchange itself and checks every result transaction.
// ----------------------------------------------------------------------------
module s5ch_result_checker (
  input  wire                        clk,
  input  wire                        rst_n,
  s5ch_in_if                         in_mon,
  s5ch_out_if                        out_mon,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [s5ch_pkg::CFG_AW-1:0] paddr,
  input  wire [31:0]                 pwdata,
  input  wire                        pready,
  output int                         pending,
  output int                         fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import s5ch_pkg::*;

  localparam logic [CFG_AW-1:0] CREDS_ADDR = CFG_AW'(4 * REG_CREDS);

  // shadow of the handshake state
  logic       creds;
  logic [2:0] phase;
  logic [8:0] position;
  logic       first_good;
  logic [7:0] reply_code;
  logic [8:0] reply_len;
  logic [3:0] held_fault;
  logic       app_shut;
  logic       net_shut;

  res_t awaited_results[$];
  int   result_index;

  initial begin
    pending = 0;
    fail_count = 0;
    result_index = 0;
  end

  function automatic void enter_fatal(input logic [3:0] code);
    phase = PH_FATAL;
    held_fault = code;
    position = '0;
  endfunction

  // One network byte on an open side outside the fatal phase.
  function automatic void track_net_byte(input logic [7:0] b, inout res_t r);
    logic [8:0] pos;
    logic [7:0] want;
    pos = position;
    if (phase == PH_EST) begin
      r.to_app_valid = 1'b1;
      r.to_app_byte = b;
      return;
    end
    if (phase == PH_METHOD || phase == PH_AUTH) begin
      want = (phase == PH_METHOD) ? SOCKS_VER : AUTH_VER;
      if (pos == 0) begin
        first_good = (b == want);
        position = 9'd1;
        return;
      end
      position = '0;
      if (!first_good) begin
        enter_fatal(phase == PH_METHOD ? FLT_METH_VER : FLT_AUTH_VER);
      end else if (phase == PH_AUTH) begin
        if (b != '0) begin
          enter_fatal(FLT_AUTH_REJECT);
        end else begin
          phase = PH_REPLY;
          reply_len = '0;
          r.send_message = SEND_CONNECT;
        end
      end else if (b == METH_NONE) begin
        phase = PH_REPLY;
        reply_len = '0;
        r.send_message = SEND_CONNECT;
      end else if (b == METH_USERPASS) begin
        if (!creds) begin
          enter_fatal(FLT_NO_CREDS);
        end else begin
          phase = PH_AUTH;
          r.send_message = SEND_CREDS;
        end
      end else begin
        enter_fatal(b == METH_REJECT ? FLT_NO_METHOD : FLT_METH_UNOFFER);
      end
      return;
    end
    if (phase != PH_REPLY) return;
    case (pos)
      9'd0: begin
        first_good = (b == SOCKS_VER);
        reply_len = '0;
      end
      9'd1: reply_code = b;
      9'd3: begin
        // version goes first, then the address type
        if (!first_good) begin
          enter_fatal(FLT_REPLY_VER);
          return;
        end
        if (b == ATYP_IPV4) reply_len = REPLY_LEN_IPV4;
        else if (b == ATYP_IPV6) reply_len = REPLY_LEN_IPV6;
        else if (b == ATYP_DOMAIN) reply_len = '0;
        else begin
          enter_fatal(FLT_ADDR_TYPE);
          return;
        end
      end
      9'd4: if (reply_len == 0) reply_len = REPLY_LEN_DOM + 9'(b);
      default: ;
    endcase
    // reply code only judged once the whole reply is in
    if (reply_len != 0 && 10'(pos) + 10'd1 >= 10'(reply_len)) begin
      position = '0;
      reply_len = '0;
      if (reply_code != 0) enter_fatal(FLT_REFUSED);
      else phase = PH_EST;
    end else begin
      position = pos + 9'd1;
    end
  endfunction

  function automatic res_t predict_result(input logic [1:0] fn, input logic [7:0] b);
    res_t r;
    r = '0;
    if (fn == FN_NET_BYTE && phase != PH_FATAL) begin
      if (net_shut) begin
        r.fault_code = FLT_SIDE_CLOSED;
      end else begin
        r.accepted = 1'b1;
        track_net_byte(b, r);
      end
    end else if (fn == FN_APP_BYTE && phase != PH_FATAL) begin
      if (app_shut) begin
        r.fault_code = FLT_SIDE_CLOSED;
      end else if (phase == PH_EST) begin
        r.accepted = 1'b1;
        r.to_net_valid = 1'b1;
        r.to_net_byte = b;
      end
    end else if (fn == FN_NET_CLOSE) begin
      r.accepted = 1'b1;
      net_shut = 1'b1;
      if (phase != PH_EST && phase != PH_FATAL) enter_fatal(FLT_NET_CLOSED);
    end else if (fn == FN_APP_CLOSE) begin
      r.accepted = 1'b1;
      app_shut = 1'b1;
    end
    if (phase == PH_FATAL) begin
      r.fault_code = held_fault;
      if (held_fault == FLT_REFUSED) r.server_reply = reply_code;
    end
    r.phase_now = phase;
    return r;
  endfunction

  function automatic string show(input res_t r);
    return $sformatf("acc=%b net=%b/%h app=%b/%h send=%0d phase=%0d fault=%0d reply=%h",
                     r.accepted, r.to_net_valid, r.to_net_byte, r.to_app_valid,
                     r.to_app_byte, r.send_message, r.phase_now, r.fault_code,
                     r.server_reply);
  endfunction

  function automatic bit same_result(input res_t a, input res_t b);
    return a.accepted === b.accepted && a.to_net_valid === b.to_net_valid &&
           a.to_net_byte === b.to_net_byte && a.to_app_valid === b.to_app_valid &&
           a.to_app_byte === b.to_app_byte && a.send_message === b.send_message &&
           a.phase_now === b.phase_now && a.fault_code === b.fault_code &&
           a.server_reply === b.server_reply;
  endfunction

  function automatic void note_failure(input string what, input res_t want, input res_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] result %0d %s: expected {%s} got {%s}", $time, result_index, what,
               show(want), show(got));
  endfunction

  always @(posedge clk) begin : track
    res_t got;
    res_t want;
    if (!rst_n) begin
      creds = 1'b0;
      phase = PH_METHOD;
      position = '0;
      first_good = 1'b0;
      reply_code = '0;
      reply_len = '0;
      held_fault = FLT_NONE;
      app_shut = 1'b0;
      net_shut = 1'b0;
      awaited_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == CREDS_ADDR) creds = pwdata[0];
      // result side first: a result never belongs to a transaction of the same edge
      if (out_mon.valid && out_mon.ready) begin
        got.accepted = out_mon.accepted;
        got.to_net_valid = out_mon.to_net_valid;
        got.to_net_byte = out_mon.to_net_byte;
        got.to_app_valid = out_mon.to_app_valid;
        got.to_app_byte = out_mon.to_app_byte;
        got.send_message = out_mon.send_message;
        got.phase_now = out_mon.phase_now;
        got.fault_code = out_mon.fault_code;
        got.server_reply = out_mon.server_reply;
        if (awaited_results.size() == 0) begin
          note_failure("unexpected", '0, got);
        end else begin
          want = awaited_results.pop_front();
          if (!same_result(want, got)) note_failure("mismatch", want, got);
        end
        result_index++;
      end
      if (in_mon.valid && in_mon.ready)
        awaited_results.push_back(predict_result(in_mon.func, in_mon.data_byte));
    end
    pending = awaited_results.size();
  end

endmodule

/* bench/socks5_client_handshake_core_tb.sv */
// ----------------------------------------------------------------------------
// socks5_client_handshake_core_tb
// Drives one SOCKS5 client session per run through the handshake core: either
// a well-formed exchange followed by random pass-through traffic and closes,
// or a handshake broken at a randomly chosen point. Both channels idle at
// random; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module socks5_client_handshake_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import s5ch_pkg::*;

  localparam logic [CFG_AW-1:0] CREDS_ADDR = CFG_AW'(4 * REG_CREDS);
  // longest quiet stretch is a sender gap plus a result stall, each from pick_gap
  localparam int IDLE_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int         pending;
  int         fail_count;
  int         idle_cycles = 0;
  bit         no_idle;
  logic [3:0] fail_cause;
  logic       use_auth;
  logic       early_app_close;
  int         hs_count;
  int         close_at;

  logic [1:0] item_kinds[4] = '{FN_NET_BYTE, FN_APP_BYTE, FN_NET_CLOSE, FN_APP_CLOSE};

  s5ch_in_if  in_ch ();
  s5ch_out_if out_ch ();

  socks5_client_handshake_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  s5ch_result_checker results_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
    logic [7:0] b;
    do b = rand_byte(); while (b == avoid);
    return b;
  endfunction

  // valid is left high after a transaction so back-to-back items need no toggle
  task automatic send_item(input logic [1:0] fn, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    // allowance after the last result is back
    repeat (2) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_AW-1:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // server byte of the handshake, with refused application bytes mixed in
  task automatic hs_send(input logic [7:0] b);
    if ($urandom_range(0, 7) == 0) send_item(FN_APP_BYTE, rand_byte());
    if (fail_cause == FLT_NET_CLOSED && hs_count == close_at)
      send_item(FN_NET_CLOSE, rand_byte());
    send_item(FN_NET_BYTE, b);
    hs_count++;
  endtask

  task automatic run_handshake();
    logic [7:0] b;
    logic [7:0] atyp;
    int         n;
    int         r;
    // method choice
    hs_send(fail_cause == FLT_METH_VER ? byte_other_than(SOCKS_VER) : SOCKS_VER);
    case (fail_cause)
      FLT_METH_VER:     b = rand_byte();
      FLT_NO_METHOD:    b = METH_REJECT;
      FLT_METH_UNOFFER: do b = rand_byte();
                        while (b == METH_NONE || b == METH_USERPASS || b == METH_REJECT);
      FLT_NO_CREDS:     b = METH_USERPASS;
      default:          b = use_auth ? METH_USERPASS : METH_NONE;
    endcase
    hs_send(b);
    if (fail_cause >= FLT_METH_VER && fail_cause <= FLT_NO_CREDS) return;
    // username/password status
    if (use_auth) begin
      hs_send(fail_cause == FLT_AUTH_VER ? byte_other_than(AUTH_VER) : AUTH_VER);
      if (fail_cause == FLT_AUTH_REJECT) hs_send(byte_other_than('0));
      else if (fail_cause == FLT_AUTH_VER) hs_send(rand_byte());
      else hs_send('0);
      if (fail_cause == FLT_AUTH_VER || fail_cause == FLT_AUTH_REJECT) return;
    end
    if (early_app_close) send_item(FN_APP_CLOSE, rand_byte());
    // CONNECT reply header
    hs_send(fail_cause == FLT_REPLY_VER ? byte_other_than(SOCKS_VER) : SOCKS_VER);
    hs_send(fail_cause == FLT_REFUSED ? byte_other_than('0) : '0);
    hs_send(rand_byte());
    if (fail_cause == FLT_ADDR_TYPE) begin
      do atyp = rand_byte(); while (atyp == ATYP_IPV4 || atyp == ATYP_IPV6 ||
                                     atyp == ATYP_DOMAIN);
    end else begin
      case ($urandom_range(0, 2))
        0:       atyp = ATYP_IPV4;
        1:       atyp = ATYP_IPV6;
        default: atyp = ATYP_DOMAIN;
      endcase
    end
    hs_send(atyp);
    if (fail_cause == FLT_REPLY_VER || fail_cause == FLT_ADDR_TYPE) return;
    // bound address and port
    if (atyp == ATYP_IPV4) begin
      n = 4;
    end else if (atyp == ATYP_IPV6) begin
      n = 16;
    end else begin
      r = $urandom_range(0, 9);
      n = (r == 0) ? 255 : (r == 1) ? 0 : $urandom_range(1, 24);
      hs_send(8'(n));
    end
    repeat (n + 2) hs_send(rand_byte());
  endtask

  // result side: random stalls
  initial begin : result_sink
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall == 0 && $urandom_range(0, 2) == 0) stall = pick_gap();
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic creds_setting;
    logic app_first;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FN_NET_BYTE;
    in_ch.data_byte = '0;
    no_idle = 1'b0;

    // one session per run: mostly well formed, otherwise broken at a random cause
    fail_cause = FLT_NONE;
    if ($urandom_range(0, 9) < 3)
      fail_cause = 4'($urandom_range(int'(FLT_METH_VER), int'(FLT_NET_CLOSED)));
    use_auth = (fail_cause == FLT_AUTH_VER || fail_cause == FLT_AUTH_REJECT) ? 1'b1 :
               1'($urandom_range(0, 1));
    creds_setting = (fail_cause == FLT_NO_CREDS) ? 1'b0 :
                    use_auth ? 1'b1 : 1'($urandom_range(0, 1));
    early_app_close = (fail_cause == FLT_NONE) && ($urandom_range(0, 15) == 0);
    close_at = $urandom_range(0, 5);
    hs_count = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_cfg(CREDS_ADDR, 32'd0);
    // application data before the session is up gets held off
    send_item(FN_APP_BYTE, 8'h00);
    send_item(FN_APP_BYTE, 8'hff);
    wait_drained();
    write_cfg(CREDS_ADDR, {31'd0, creds_setting});

    run_handshake();
    if (fail_cause == FLT_NONE) begin
      send_item(FN_NET_BYTE, 8'h00);
      send_item(FN_NET_BYTE, 8'hff);
      send_item(FN_APP_BYTE, 8'h00);
      send_item(FN_APP_BYTE, 8'hff);
    end
    // sender holds off until every result is back
    wait_drained();
    write_cfg(CREDS_ADDR, {31'd0, ~creds_setting});

    if (fail_cause == FLT_NONE) begin
      for (int blk = 0; blk < 12; blk++) begin
        no_idle = ($urandom_range(0, 3) == 0);
        if (blk == 6) begin
          wait_drained();
          write_cfg(CREDS_ADDR, {31'd0, 1'($urandom_range(0, 1))});
        end
        repeat (96) send_item(item_kinds[$urandom_range(0, 1)], rand_byte());
      end
      no_idle = 1'b0;
      // shut both sides down in random order, with traffic on the closed side
      app_first = 1'($urandom_range(0, 1));
      send_item(app_first ? FN_APP_CLOSE : FN_NET_CLOSE, rand_byte());
      repeat (10) send_item(item_kinds[$urandom_range(0, 1)], rand_byte());
      send_item(app_first ? FN_NET_CLOSE : FN_APP_CLOSE, rand_byte());
      repeat (6) send_item(item_kinds[$urandom_range(0, 1)], rand_byte());
    end else begin
      repeat (1100) send_item(item_kinds[$urandom_range(0, 3)], rand_byte());
    end

    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
